>>> hdl/fskl_pkg.sv
package fskl_pkg;

  localparam int BUCKET_COUNT = 257;
  localparam int BUCKET_AW = 9;
  localparam int BOUND_W = 13;
  localparam int KEY_W = 160;
  localparam int PAYLOAD_W = 40;
  localparam int ENTRY_W = KEY_W + PAYLOAD_W;

  localparam logic [1:0] OP_BOUND = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic CFG_DATE_LIMIT = 1'b0;
  localparam logic CFG_CACHE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATE,
    ST_RDB1,
    ST_RDB2,
    ST_INIT,
    ST_ADDR,
    ST_CMP,
    ST_DECIDE
  } step_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_START,
    COND_LATE,
    COND_EMPTY,
    COND_SEARCH
  } cond_t;

  typedef struct packed {
    logic  bnd_rd;
    logic  bnd_hi;
    logic  ld_first;
    logic  ld_last;
    logic  ent_rd;
    logic  ld_cmp;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic take;
    logic bnd_rd;
    logic bnd_hi;
    logic ld_first;
    logic ld_last;
    logic ent_rd;
    logic ld_cmp;
    logic init;
    logic lo_inc;
    logic lo_mid;
    logic hi_mid;
    logic emit;
    logic hit;
  } cmd_t;

  typedef struct packed {
    logic late;
    logic empty;
    logic key_eq;
    logic key_gt;
    logic adj;
    logic same;
    logic slice_ok;
  } status_t;

  function automatic uword_t ucode(input step_t step);
    uword_t uw;
    uw = '{bnd_rd: 1'b0, bnd_hi: 1'b0, ld_first: 1'b0, ld_last: 1'b0, ent_rd: 1'b0,
           ld_cmp: 1'b0, cond: COND_NONE, target: ST_IDLE};
    case (step)
      ST_IDLE: begin
        uw.cond = COND_START;
        uw.target = ST_DATE;
      end
      ST_DATE: begin
        uw.bnd_rd = 1'b1;
        uw.cond = COND_LATE;
        uw.target = ST_RDB1;
      end
      ST_RDB1: begin
        uw.bnd_rd = 1'b1;
        uw.bnd_hi = 1'b1;
        uw.ld_first = 1'b1;
        uw.target = ST_RDB2;
      end
      ST_RDB2: begin
        uw.ld_last = 1'b1;
        uw.target = ST_INIT;
      end
      ST_INIT: begin
        uw.cond = COND_EMPTY;
        uw.target = ST_ADDR;
      end
      ST_ADDR: begin
        uw.ent_rd = 1'b1;
        uw.target = ST_CMP;
      end
      ST_CMP: begin
        uw.ld_cmp = 1'b1;
        uw.target = ST_DECIDE;
      end
      ST_DECIDE: begin
        uw.cond = COND_SEARCH;
        uw.target = ST_ADDR;
      end
      default: begin
        uw.target = ST_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

>>> hdl/fskl_ram.sv
module fskl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/fskl_seq.sv
module fskl_seq
  import fskl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] opcode,
  input  status_t   st,
  output logic      busy,
  output cmd_t      cmd
);

  step_t  step;
  step_t  step_next;
  uword_t uw;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    uw = ucode(step);
    busy = (step != ST_IDLE);
    step_next = uw.target;
    cmd = '0;
    cmd.bnd_rd = uw.bnd_rd;
    cmd.bnd_hi = uw.bnd_hi;
    cmd.ld_first = uw.ld_first;
    cmd.ld_last = uw.ld_last;
    cmd.ent_rd = uw.ent_rd;
    cmd.ld_cmp = uw.ld_cmp;
    case (uw.cond)
      COND_START: begin
        cmd.take = start;
        if (!(start && opcode == OP_LOOKUP)) begin
          step_next = ST_IDLE;
        end
      end
      COND_LATE: begin
        if (st.late) begin
          cmd.emit = 1'b1;
          step_next = ST_IDLE;
        end
      end
      COND_EMPTY: begin
        if (st.empty) begin
          cmd.emit = 1'b1;
          step_next = ST_IDLE;
        end else begin
          cmd.init = 1'b1;
        end
      end
      COND_SEARCH: begin
        if (st.key_eq) begin
          cmd.emit = 1'b1;
          cmd.hit = st.slice_ok;
          step_next = ST_IDLE;
        end else if (st.adj) begin
          cmd.lo_inc = 1'b1;
        end else if (st.same) begin
          cmd.emit = 1'b1;
          step_next = ST_IDLE;
        end else if (st.key_gt) begin
          cmd.lo_mid = 1'b1;
        end else begin
          cmd.hi_mid = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/fskl_datapath.sv
module fskl_datapath
  import fskl_pkg::*;
#(
  parameter int ENTRY_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [1:0]  opcode,
  input  logic [8:0]  bucket,
  input  logic [12:0] bound,
  input  logic [11:0] slot,
  input  logic [63:0] key_high,
  input  logic [63:0] key_mid,
  input  logic [31:0] key_low,
  input  logic        start_mark,
  input  logic [6:0]  slice_number,
  input  logic [31:0] position,
  input  logic [31:0] commit_date,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        found,
  output logic        start_flag,
  output logic [6:0]  slice_index,
  output logic [31:0] found_position
);

  localparam int AW = $clog2(ENTRY_DEPTH);
  localparam int CW = $clog2(ENTRY_DEPTH + 1);

  logic [31:0]          max_commit_date;
  logic [7:0]           cache_count;
  logic [63:0]          kh;
  logic [63:0]          km;
  logic [31:0]          kl;
  logic [31:0]          date;
  logic [BOUND_W-1:0]   first;
  logic [CW-1:0]        last;
  logic [AW-1:0]        lo;
  logic [AW-1:0]        hi;
  logic [AW:0]          mid_sum;
  logic [AW-1:0]        mid;
  logic                 hi_eq, hi_gt, mid_eq, mid_gt, low_eq, low_gt;
  logic [PAYLOAD_W-1:0] payload;

  logic                 bnd_we;
  logic [BUCKET_AW-1:0] bnd_raddr;
  logic [BOUND_W-1:0]   bnd_rdata;
  logic                 ent_we;
  logic [AW-1:0]        ent_waddr;
  logic [AW-1:0]        ent_raddr;
  logic [ENTRY_W-1:0]   ent_wdata;
  logic [ENTRY_W-1:0]   ent_rdata;
  logic [31:0]          bnd_ext;

  assign bnd_we = cmd.take && opcode == OP_BOUND && 32'(bucket) < BUCKET_COUNT;
  assign bnd_raddr = {1'b0, kh[63:56]} + {{(BUCKET_AW-1){1'b0}}, cmd.bnd_hi};
  assign ent_we = cmd.take && opcode == OP_ENTRY && 32'(slot) < ENTRY_DEPTH;
  assign ent_waddr = AW'(32'(slot));
  assign ent_wdata = {key_high, key_mid, key_low, start_mark, slice_number, position};
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[AW:1];
  assign ent_raddr = AW'(32'(first) + 32'(mid));
  assign bnd_ext = 32'(bnd_rdata);

  fskl_ram #(
    .WIDTH(BOUND_W),
    .DEPTH(BUCKET_COUNT)
  ) u_bounds (
    .clk(clk),
    .we(bnd_we),
    .waddr(bucket),
    .wdata(bound),
    .re(cmd.bnd_rd),
    .raddr(bnd_raddr),
    .rdata(bnd_rdata)
  );

  fskl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRY_DEPTH)
  ) u_entries (
    .clk(clk),
    .we(ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .re(cmd.ent_rd),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  always_comb begin
    st.late = date > max_commit_date;
    st.empty = 32'(last) <= 32'(first);
    st.key_eq = hi_eq && mid_eq && low_eq;
    st.key_gt = hi_gt || (hi_eq && mid_gt) || (hi_eq && mid_eq && low_gt);
    st.adj = ({1'b0, lo} + (AW+1)'(1)) == {1'b0, hi};
    st.same = (lo == hi);
    st.slice_ok = {1'b0, payload[38:32]} < cache_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_commit_date <= '0;
      cache_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATE_LIMIT: max_commit_date <= cfg_data;
        CFG_CACHE_COUNT: cache_count <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kh <= key_high;
      km <= key_mid;
      kl <= key_low;
      date <= commit_date;
    end
    if (cmd.ld_first) begin
      first <= bnd_rdata;
    end
    if (cmd.ld_last) begin
      last <= (bnd_ext > ENTRY_DEPTH) ? CW'(ENTRY_DEPTH) : CW'(bnd_ext);
    end
    if (cmd.init) begin
      lo <= '0;
      hi <= AW'(32'(last) - 32'(first) - 32'd1);
    end else if (cmd.lo_inc) begin
      lo <= lo + AW'(1);
    end else if (cmd.lo_mid) begin
      lo <= mid;
    end else if (cmd.hi_mid) begin
      hi <= mid;
    end
    if (cmd.ld_cmp) begin
      hi_eq <= kh == ent_rdata[199:136];
      hi_gt <= kh > ent_rdata[199:136];
      mid_eq <= km == ent_rdata[135:72];
      mid_gt <= km > ent_rdata[135:72];
      low_eq <= kl == ent_rdata[71:40];
      low_gt <= kl > ent_rdata[71:40];
      payload <= ent_rdata[39:0];
    end
    if (cmd.emit) begin
      found <= cmd.hit;
      start_flag <= cmd.hit & payload[39];
      slice_index <= cmd.hit ? payload[38:32] : 7'd0;
      found_position <= cmd.hit ? payload[31:0] : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

>>> hdl/fanout_sorted_key_lookup_top.sv
// Writes of bounds and entries take effect in the cycle of acceptance and give no result.
// A lookup whose date is past the configured limit ends in the date step as a miss.
// Other lookups read the bucket bounds, then make P probes of the entry memory.
// P is at most about log2 of the bucket size plus two; one lookup is in flight at a time.
// Each result is held for one cycle with done high; the receiver cannot stall.
// Synchronous reset clears the sequencer, the done strobe and the configuration registers.
module fanout_sorted_key_lookup_top
  import fskl_pkg::*;
#(
  parameter int ENTRY_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [8:0]  bucket,
  input  logic [12:0] bound,
  input  logic [11:0] slot,
  input  logic [63:0] key_high,
  input  logic [63:0] key_mid,
  input  logic [31:0] key_low,
  input  logic        start_mark,
  input  logic [6:0]  slice_number,
  input  logic [31:0] position,
  input  logic [31:0] commit_date,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        found,
  output logic        start_flag,
  output logic [6:0]  slice_index,
  output logic [31:0] found_position
);

  cmd_t    cmd;
  status_t st;

  fskl_seq u_seq (
    .clk(clk),
    .rst(rst),
    .start(start),
    .opcode(opcode),
    .st(st),
    .busy(busy),
    .cmd(cmd)
  );

  fskl_datapath #(
    .ENTRY_DEPTH(ENTRY_DEPTH)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .st(st),
    .opcode(opcode),
    .bucket(bucket),
    .bound(bound),
    .slot(slot),
    .key_high(key_high),
    .key_mid(key_mid),
    .key_low(key_low),
    .start_mark(start_mark),
    .slice_number(slice_number),
    .position(position),
    .commit_date(commit_date),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .found(found),
    .start_flag(start_flag),
    .slice_index(slice_index),
    .found_position(found_position)
  );

endmodule
